// ----- rtl/ppc_pkg.sv -----
// Shared constants and interface types for the prime parity counter.
package ppc_pkg;

	// Default widths of the value path and the running totals
	localparam int VALUE_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF = 32;

	// Fixed field widths on the stream ports
	localparam int VALUE_W     = 32;
	localparam int TOTAL_W     = 32;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 104;

	// Status of the shared remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Verdict handed from the trial-division sequencer to the top level
	typedef struct packed {
		logic done;
		logic prime;
	} seq_res_t;

endpackage

// ----- rtl/prime_parity_counter.sv -----
// Top level: stream ports, saturating totals and the result register.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata[31:0] value, s_tlast end_of_list
//  m_*      out  m_tvalid/m_tready  m_tdata flags and totals, m_tlast list_done
//
// Negative values, values below 3 and even values are settled without the divider.
// An odd value n runs one bit-serial division per odd divisor tried, up to
// sqrt(n)/2 divisors, in a divider of width W = min(VALUE_BITS, 32).
// Reset clears the totals; a list end clears them after its result is stored.
// One result register: the next transaction is accepted while a result waits,
// and a finished item holds until the register is free.
module prime_parity_counter
	import ppc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [31:0] value
	input  logic                   s_tlast,  // end_of_list
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] is_even_flag, [1] is_odd_flag, [2] is_prime_flag, [3] negative_error,
	// [35:4] odd_total, [67:36] even_total, [99:68] prime_total, [103:100] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast   // list_done
);

	localparam int NW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int EXT_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
	localparam int PAD_W = OUT_TDATA_W - 4 - 3 * TOTAL_W;

	logic                  s_fire;
	logic                  commit;
	logic                  busy_q;
	logic                  pend_q;
	logic                  prime_q;
	logic                  neg_q;
	logic                  last_q;
	logic                  even_q;
	logic                  m_valid_q;
	logic [NW-1:0]         raw;
	logic                  raw_neg;
	logic [NW-1:0]         seq_n;
	seq_res_t              res;
	logic [COUNT_BITS-1:0] odd_cnt_q, even_cnt_q, prime_cnt_q;
	logic [COUNT_BITS-1:0] odd_nx, even_nx, prime_nx;
	logic                  odd_inc, even_inc, prime_inc;
	logic [EXT_W-1:0]      odd_ext, even_ext, prime_ext;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic                  m_last_q;

	// Input transaction and value decode
	assign s_tready = !busy_q;
	assign s_fire   = s_tvalid && s_tready;
	assign raw      = s_tdata[NW-1:0];
	assign raw_neg  = raw[NW-1];
	assign seq_n    = raw_neg ? '0 : raw;

	ppc_prime_seq #(.W(NW)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_fire),
		.n      (seq_n),
		.res    (res)
	);

	// Move a finished item into the result register once it is free
	assign commit = pend_q && (!m_valid_q || m_tready);

	// Saturating totals after this item
	assign odd_inc   = !neg_q && !even_q;
	assign even_inc  = !neg_q && even_q;
	assign prime_inc = !neg_q && prime_q;
	assign odd_nx    = (odd_inc && odd_cnt_q != '1) ?
		odd_cnt_q + COUNT_BITS'(1) : odd_cnt_q;
	assign even_nx   = (even_inc && even_cnt_q != '1) ?
		even_cnt_q + COUNT_BITS'(1) : even_cnt_q;
	assign prime_nx  = (prime_inc && prime_cnt_q != '1) ?
		prime_cnt_q + COUNT_BITS'(1) : prime_cnt_q;
	assign odd_ext   = EXT_W'(odd_nx);
	assign even_ext  = EXT_W'(even_nx);
	assign prime_ext = EXT_W'(prime_nx);

	// Control: item in flight, verdict pending, result valid, totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			m_valid_q   <= 1'b0;
			odd_cnt_q   <= '0;
			even_cnt_q  <= '0;
			prime_cnt_q <= '0;
		end else begin
			if (s_fire) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (res.done) begin
				pend_q <= 1'b1;
			end else if (commit) begin
				pend_q <= 1'b0;
			end
			if (commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (commit) begin
				if (last_q) begin
					odd_cnt_q   <= '0;
					even_cnt_q  <= '0;
					prime_cnt_q <= '0;
				end else begin
					odd_cnt_q   <= odd_nx;
					even_cnt_q  <= even_nx;
					prime_cnt_q <= prime_nx;
				end
			end
		end
	end

	// Item attributes captured at acceptance, verdict captured at finish
	always_ff @(posedge clk) begin
		if (s_fire) begin
			neg_q  <= raw_neg;
			last_q <= s_tlast;
			even_q <= !raw[0];
		end
		if (res.done) begin
			prime_q <= res.prime;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (commit) begin
			m_data_q <= {PAD_W'(0), prime_ext[TOTAL_W-1:0], even_ext[TOTAL_W-1:0],
				odd_ext[TOTAL_W-1:0], neg_q, prime_inc, odd_inc, even_inc};
			m_last_q <= last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_commit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> busy_q)
		else $error("result stored with no item in flight");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_tready)
		else $error("second item accepted while one is in flight");
	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> ($stable(odd_cnt_q) && $stable(even_cnt_q) && $stable(prime_cnt_q)))
		else $error("totals changed without a stored result");
`endif

endmodule

// ----- rtl/ppc_divider.sv -----
// Restoring divider: one quotient bit per cycle, shared by every trial divisor.
module ppc_divider
	import ppc_pkg::*;
#(
	parameter int W = VALUE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder,
	output div_stat_t    stat
);

	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W:0]       rs;
	logic [W:0]       diff;

	// Shift in the next dividend bit and try the subtraction
	assign rs   = {rem_q, quo_q[W-1]};
	assign diff = rs - {1'b0, divisor};

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= diff[W] ? rs[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~diff[W]};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

// ----- rtl/ppc_prime_seq.sv -----
// Trial-division sequencer: steps odd divisors through the shared divider.
module ppc_prime_seq
	import ppc_pkg::*;
#(
	parameter int W = VALUE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] n,
	output seq_res_t     res
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_LAUNCH = 3'b010,
		S_WAIT   = 3'b100
	} seq_state_t;

	seq_state_t   state_q;
	seq_res_t     res_q;
	logic [W-1:0] n_q;
	logic [W-1:0] d_q;
	logic [W-1:0] quo;
	logic [W-1:0] rem;
	div_stat_t    dstat;
	logic         div_start;
	logic         fin;
	logic         fin_prime;

	assign div_start = (state_q == S_LAUNCH);

	ppc_divider #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (d_q),
		.quotient  (quo),
		.remainder (rem),
		.stat      (dstat)
	);

	// Verdict: settle the trivial cases at once, otherwise at the deciding divisor
	always_comb begin
		fin       = 1'b0;
		fin_prime = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start && (n < W'(3) || !n[0])) begin
					fin       = 1'b1;
					fin_prime = (n == W'(2));
				end
			end
			S_WAIT: begin
				if (dstat.done && (d_q > quo || rem == '0)) begin
					fin       = 1'b1;
					fin_prime = (d_q > quo);
				end
			end
			default: begin
			end
		endcase
	end

	// Control: iterate divisors until a verdict is reached
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= '0;
		end else begin
			res_q <= '{done: fin, prime: fin_prime};
			unique case (state_q)
				S_IDLE: begin
					if (start && !fin) begin
						state_q <= S_LAUNCH;
					end
				end
				S_LAUNCH: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (dstat.done) begin
						state_q <= fin ? S_IDLE : S_LAUNCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operand and divisor registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			n_q <= n;
			d_q <= W'(3);
		end else if (state_q == S_WAIT && dstat.done) begin
			d_q <= d_q + W'(2);
		end
	end

	assign res = res_q;

`ifndef SYNTHESIS
	a_launch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LAUNCH) |-> !dstat.busy)
		else $error("divider launched while still busy");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> (state_q == S_WAIT))
		else $error("divider finished outside the wait state");
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.done |-> (state_q == S_IDLE))
		else $error("verdict given while a test is still running");
`endif

endmodule
